[hdl/gwawb_pkg.sv]
// Shared types, constants and coefficient tables for the grey-world AWB gain update.
// Used by gwawb_div and grey_world_awb_gain_update; depends on nothing.
package gwawb_pkg;

    // Divider datapath widths
    localparam int DIV_W  = 68;
    localparam int QUO_W  = 40;
    localparam int STEP_W = 6;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_RGB_MODE    = 3'd0;
    localparam logic [2:0] REG_AUTO_ENABLE = 3'd1;
    localparam logic [2:0] REG_MANUAL_RED  = 3'd2;
    localparam logic [2:0] REG_MANUAL_BLUE = 3'd3;
    localparam logic [2:0] REG_SPEED       = 3'd4;

    // Fixed-point limits
    localparam logic [17:0] GAIN_MAX_Q16 = 18'd261888;
    localparam logic signed [63:0] CUBIC_OFFSET = 64'sd5788481126;

    typedef struct packed {
        logic [7:0] mean_y_or_green;
        logic [7:0] mean_cb_or_blue;
        logic [7:0] mean_cr_or_red;
        logic [9:0] applied_red_gain;
        logic [9:0] applied_green_gain;
        logic [9:0] applied_blue_gain;
    } in_word_t;

    typedef struct packed {
        logic [9:0]  next_red_gain;
        logic [9:0]  next_green_gain;
        logic [9:0]  next_blue_gain;
        logic [15:0] colour_temp_kelvin;
        logic        temp_invalid;
    } out_word_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // YCbCr to RGB, Q.12; row is r/g/b, column is y/cb/cr
    function automatic logic signed [13:0] ycc_coef(input logic [1:0] row,
                                                    input logic [1:0] col);
        logic signed [13:0] c;
        c = 14'sd0;
        case ({row, col})
            4'b0000: c = 14'sd4766;
            4'b0001: c = -14'sd255;
            4'b0010: c = 14'sd6557;
            4'b0100: c = 14'sd4766;
            4'b0101: c = -14'sd1657;
            4'b0110: c = -14'sd3256;
            4'b1000: c = 14'sd4766;
            4'b1001: c = 14'sd8156;
            4'b1010: c = -14'sd102;
            default: c = 14'sd0;
        endcase
        return c;
    endfunction

    // Folded XYZ chromaticity terms; row is S, numerator, denominator; column r/g/b
    function automatic logic signed [33:0] chroma_coef(input logic [1:0] row,
                                                       input logic [1:0] col);
        logic signed [33:0] c;
        c = 34'sd0;
        case ({row, col})
            4'b0000: c = -34'sd75334;
            4'b0001: c = 34'sd255482;
            4'b0010: c = -34'sd73727;
            4'b0100: c = 34'sd1025700212;
            4'b0101: c = 34'sd1095158260;
            4'b0110: c = -34'sd2503578878;
            4'b1000: c = 34'sd477067354;
            4'b1001: c = -34'sd3668039526;
            4'b1010: c = 34'sd2245726097;
            default: c = 34'sd0;
        endcase
        return c;
    endfunction

endpackage

[hdl/grey_world_awb_gain_update.sv]
// Grey-world AWB gain update: one frame's colour means and applied gains in,
// next frame's gains and an estimated colour temperature out, one word each.
// Most of the work is in the shared one-bit-per-cycle divider (three 32-step gain
// removals, one 23-step chromaticity ratio, two 40-step grey-world ratios; a zero
// divisor or ratio overflow skips a division); the matrix and cubic terms go
// through one shared 40x25 multiplier, one product a cycle. Input stalls from
// acceptance until the result is loaded into the output register; a finished
// result may wait there while the next word is accepted.
module grey_world_awb_gain_update import gwawb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_word
);

    typedef enum logic [10:0] {
        PH_IDLE   = 11'b000_0000_0001,
        PH_CONV   = 11'b000_0000_0010,
        PH_UNAP   = 11'b000_0000_0100,
        PH_CHROMA = 11'b000_0000_1000,
        PH_TCHK   = 11'b000_0001_0000,
        PH_TDIV   = 11'b000_0010_0000,
        PH_CUBIC  = 11'b000_0100_0000,
        PH_GSET   = 11'b000_1000_0000,
        PH_GDIV   = 11'b001_0000_0000,
        PH_FILT   = 11'b010_0000_0000,
        PH_DONE   = 11'b100_0000_0000
    } phase_t;

    // configuration
    logic        rgb_mode_reg;
    logic        auto_en_reg;
    logic [9:0]  man_red_reg;
    logic [9:0]  man_blue_reg;
    logic [8:0]  speed_reg;
    logic        cfg_wr;

    // sequencer and datapath state
    phase_t                phase_reg,  phase_next;
    logic [2:0]            cnt_reg,    cnt_next;
    logic [1:0]            ch_reg,     ch_next;
    in_word_t              in_reg,     in_next;
    logic signed [63:0]    acc_reg,    acc_next;
    logic signed [64:0]    p_reg,      p_next;
    logic signed [23:0]    mean_r_reg, mean_r_next;
    logic signed [23:0]    mean_g_reg, mean_g_next;
    logic signed [23:0]    mean_b_reg, mean_b_next;
    logic signed [63:0]    s_reg,      s_next;
    logic signed [63:0]    num_reg,    num_next;
    logic signed [63:0]    den_reg,    den_next;
    logic                  neg_reg,    neg_next;
    logic                  gneg_reg,   gneg_next;
    logic                  bad_reg,    bad_next;
    logic [15:0]           temp_reg,   temp_next;
    logic [22:0]           m_reg,      m_next;
    logic [29:0]           m2_reg,     m2_next;
    logic [36:0]           m3_reg,     m3_next;
    logic signed [27:0]    est_reg,    est_next;
    logic [17:0]           ared_reg,   ared_next;
    logic [17:0]           ablu_reg,   ablu_next;
    out_word_t             out_reg,    out_next;
    logic                  out_valid_reg;
    logic                  out_load;

    // shared units
    logic signed [39:0]    mul_a;
    logic signed [24:0]    mul_b;
    div_ctrl_t             div_ctrl;
    div_stat_t             div_stat;
    logic [DIV_W-1:0]      div_num;
    logic [DIV_W-1:0]      div_dsh;
    logic [QUO_W-1:0]      div_quo;

    // derived values
    logic signed [63:0]    sum_ap;
    logic signed [8:0]     chroma_k;
    logic signed [23:0]    mean_k;
    logic signed [23:0]    mean_c;
    logic [23:0]           mean_mag_c;
    logic [9:0]            gain_c;
    logic signed [23:0]    unap_val;
    logic [63:0]           num_mag;
    logic [63:0]           den_mag;
    logic signed [23:0]    other_c;
    logic signed [24:0]    gdiv_d;
    logic [24:0]           gdiv_d_mag;
    logic [23:0]           green_mag;
    logic [26:0]           est_mag;
    logic [17:0]           stored_c;
    logic [8:0]            speed_sat;
    logic [8:0]            speed_inv;
    logic signed [63:0]    filt_q;
    logic [17:0]           filt_clamped;
    logic signed [37:0]    n3_s;
    logic signed [23:0]    n_s;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgb_mode_reg <= 1'b0;
            auto_en_reg  <= 1'b1;
            man_red_reg  <= 10'd256;
            man_blue_reg <= 10'd256;
            speed_reg    <= 9'd51;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_RGB_MODE:    rgb_mode_reg <= pwdata[0];
                REG_AUTO_ENABLE: auto_en_reg  <= pwdata[0];
                REG_MANUAL_RED:  man_red_reg  <= pwdata[9:0];
                REG_MANUAL_BLUE: man_blue_reg <= pwdata[9:0];
                REG_SPEED:       speed_reg    <= pwdata[8:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_RGB_MODE:    prdata = {31'b0, rgb_mode_reg};
            REG_AUTO_ENABLE: prdata = {31'b0, auto_en_reg};
            REG_MANUAL_RED:  prdata = {22'b0, man_red_reg};
            REG_MANUAL_BLUE: prdata = {22'b0, man_blue_reg};
            REG_SPEED:       prdata = {23'b0, speed_reg};
            default:         prdata = 32'b0;
        endcase
    end

    // ---------------- operand selection ----------------
    assign sum_ap = acc_reg + signed'(p_reg[63:0]);

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    chroma_k = signed'({1'b0, in_reg.mean_y_or_green}) - 9'sd16;
            2'd1:    chroma_k = signed'({1'b0, in_reg.mean_cb_or_blue}) - 9'sd128;
            2'd2:    chroma_k = signed'({1'b0, in_reg.mean_cr_or_red}) - 9'sd128;
            default: chroma_k = 9'sd0;
        endcase
        case (cnt_reg[1:0])
            2'd0:    mean_k = mean_r_reg;
            2'd1:    mean_k = mean_g_reg;
            2'd2:    mean_k = mean_b_reg;
            default: mean_k = 24'sd0;
        endcase
        case (ch_reg)
            2'd0:
            begin
                mean_c = mean_r_reg;
                gain_c = in_reg.applied_red_gain;
            end
            2'd1:
            begin
                mean_c = mean_g_reg;
                gain_c = in_reg.applied_green_gain;
            end
            default:
            begin
                mean_c = mean_b_reg;
                gain_c = in_reg.applied_blue_gain;
            end
        endcase
    end

    // gain removal: zero gain counts as one LSB, result saturates to 24 bits
    assign mean_mag_c = mean_c[23] ? 24'(-mean_c) : 24'(mean_c);
    always_comb
    begin
        if (!mean_c[23])
            unap_val = (div_quo > 40'd8388607) ? 24'sd8388607 : signed'(div_quo[23:0]);
        else
            unap_val = (div_quo > 40'd8388608) ? -24'sd8388608 : -signed'(div_quo[23:0]);
    end

    assign num_mag = num_reg[63] ? 64'(-num_reg) : 64'(num_reg);
    assign den_mag = den_reg[63] ? 64'(-den_reg) : 64'(den_reg);

    // cubic terms carry the ratio's sign
    assign n3_s = neg_reg ? -signed'({1'b0, m3_reg}) : signed'({1'b0, m3_reg});
    assign n_s  = neg_reg ? -signed'({1'b0, m_reg})  : signed'({1'b0, m_reg});

    // grey-world ratio green / (other + 1.0)
    assign other_c    = (ch_reg == 2'd0) ? mean_r_reg : mean_b_reg;
    assign gdiv_d     = 25'(other_c) + 25'sd4096;
    assign gdiv_d_mag = gdiv_d[24] ? 25'(-gdiv_d) : 25'(gdiv_d);
    assign green_mag  = mean_g_reg[23] ? 24'(-mean_g_reg) : 24'(mean_g_reg);
    // beyond 2^26 the filtered value clamps the same way for any non-zero weight
    assign est_mag    = (div_quo >= 40'd67108864) ? 27'd67108864 : div_quo[26:0];

    // first-order filter
    assign stored_c  = (ch_reg == 2'd0) ? ared_reg : ablu_reg;
    assign speed_sat = (speed_reg > 9'd256) ? 9'd256 : speed_reg;
    assign speed_inv = 9'd256 - speed_sat;
    assign filt_q    = sum_ap[63] ? ((sum_ap + 64'sd255) >>> 8) : (sum_ap >>> 8);
    always_comb
    begin
        if (filt_q[63])
            filt_clamped = 18'd0;
        else if (filt_q > signed'({46'b0, GAIN_MAX_Q16}))
            filt_clamped = GAIN_MAX_Q16;
        else
            filt_clamped = filt_q[17:0];
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = 40'sd0;
        mul_b = 25'sd0;
        case (phase_reg)
            PH_CONV:
            begin
                mul_a = 40'(ycc_coef(ch_reg, cnt_reg[1:0]));
                mul_b = 25'(chroma_k);
            end
            PH_CHROMA:
            begin
                mul_a = 40'(chroma_coef(ch_reg, cnt_reg[1:0]));
                mul_b = 25'(mean_k);
            end
            PH_CUBIC:
            begin
                case (cnt_reg)
                    3'd0:
                    begin
                        mul_a = signed'({17'b0, m_reg});
                        mul_b = signed'({2'b0, m_reg});
                    end
                    3'd2:
                    begin
                        mul_a = signed'({10'b0, m2_reg});
                        mul_b = signed'({2'b0, m_reg});
                    end
                    3'd4:
                    begin
                        mul_a = 40'(n3_s);
                        mul_b = 25'sd7184;
                    end
                    3'd5:
                    begin
                        mul_a = signed'({10'b0, m2_reg});
                        mul_b = 25'sd56400;
                    end
                    3'd6:
                    begin
                        mul_a = 40'(n_s);
                        mul_b = 25'sd109173;
                    end
                    default:
                    begin
                        mul_a = 40'sd0;
                        mul_b = 25'sd0;
                    end
                endcase
            end
            PH_FILT:
            begin
                if (cnt_reg == 3'd0)
                begin
                    mul_a = 40'(est_reg);
                    mul_b = signed'({16'b0, speed_sat});
                end
                else
                begin
                    mul_a = signed'({22'b0, stored_c});
                    mul_b = signed'({16'b0, speed_inv});
                end
            end
            default:
            begin
                mul_a = 40'sd0;
                mul_b = 25'sd0;
            end
        endcase
    end

    assign p_next = mul_a * mul_b;

    // ---------------- sequencer ----------------
    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        ch_next     = ch_reg;
        in_next     = in_reg;
        acc_next    = acc_reg;
        mean_r_next = mean_r_reg;
        mean_g_next = mean_g_reg;
        mean_b_next = mean_b_reg;
        s_next      = s_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        neg_next    = neg_reg;
        gneg_next   = gneg_reg;
        bad_next    = bad_reg;
        temp_next   = temp_reg;
        m_next      = m_reg;
        m2_next     = m2_reg;
        m3_next     = m3_reg;
        est_next    = est_reg;
        ared_next   = ared_reg;
        ablu_next   = ablu_reg;
        out_next    = out_reg;
        out_load    = 1'b0;
        div_ctrl    = '0;
        div_num     = '0;
        div_dsh     = '0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (in_valid)
                begin
                    in_next   = in_word;
                    cnt_next  = 3'd0;
                    ch_next   = 2'd0;
                    bad_next  = 1'b0;
                    temp_next = 16'd0;
                    if (rgb_mode_reg)
                    begin
                        mean_g_next = signed'({4'b0, in_word.mean_y_or_green, 12'b0});
                        mean_b_next = signed'({4'b0, in_word.mean_cb_or_blue, 12'b0});
                        mean_r_next = signed'({4'b0, in_word.mean_cr_or_red, 12'b0});
                        phase_next  = PH_UNAP;
                    end
                    else
                        phase_next = PH_CONV;
                end
            end

            // three-term dot product per colour; each product is registered in p_reg before it is summed
            PH_CONV, PH_CHROMA:
            begin
                cnt_next = cnt_reg + 3'd1;
                case (cnt_reg)
                    3'd1: acc_next = signed'(p_reg[63:0]);
                    3'd2: acc_next = sum_ap;
                    3'd3:
                    begin
                        cnt_next = 3'd0;
                        if (phase_reg == PH_CONV)
                        begin
                            case (ch_reg)
                                2'd0:    mean_r_next = sum_ap[23:0];
                                2'd1:    mean_g_next = sum_ap[23:0];
                                default: mean_b_next = sum_ap[23:0];
                            endcase
                        end
                        else
                        begin
                            case (ch_reg)
                                2'd0:    s_next   = sum_ap;
                                2'd1:    num_next = sum_ap;
                                default: den_next = sum_ap;
                            endcase
                        end
                        if (ch_reg == 2'd2)
                        begin
                            ch_next    = 2'd0;
                            phase_next = (phase_reg == PH_CONV) ? PH_UNAP : PH_TCHK;
                        end
                        else
                            ch_next = ch_reg + 2'd1;
                    end
                    default: ;
                endcase
            end

            // divide out the applied gain of each colour
            PH_UNAP:
            begin
                if (cnt_reg == 3'd0)
                begin
                    div_ctrl.start = 1'b1;
                    div_ctrl.steps = STEP_W'(32);
                    div_num        = DIV_W'({mean_mag_c, 8'b0});
                    div_dsh        = DIV_W'({((gain_c == 10'd0) ? 10'd1 : gain_c), 32'b0});
                    cnt_next       = 3'd1;
                end
                else if (div_stat.done)
                begin
                    case (ch_reg)
                        2'd0:    mean_r_next = unap_val;
                        2'd1:    mean_g_next = unap_val;
                        default: mean_b_next = unap_val;
                    endcase
                    cnt_next = 3'd0;
                    if (ch_reg == 2'd2)
                    begin
                        ch_next    = 2'd0;
                        phase_next = PH_CHROMA;
                    end
                    else
                        ch_next = ch_reg + 2'd1;
                end
            end

            // zero divisors and ratio overflow are caught before dividing
            PH_TCHK:
            begin
                cnt_next = 3'd0;
                ch_next  = 2'd0;
                if (s_reg == 64'sd0 || den_reg == 64'sd0)
                begin
                    bad_next   = 1'b1;
                    temp_next  = 16'd0;
                    phase_next = PH_GSET;
                end
                else
                begin
                    neg_next = num_reg[63] ^ den_reg[63];
                    if ({7'b0, num_mag} >= {den_mag, 7'b0})
                    begin
                        m_next     = 23'h7F_FFFF;
                        bad_next   = 1'b1;
                        phase_next = PH_CUBIC;
                    end
                    else
                    begin
                        div_ctrl.start = 1'b1;
                        div_ctrl.steps = STEP_W'(23);
                        div_num        = DIV_W'(num_mag);
                        div_dsh        = {den_mag[60:0], 7'b0};
                        phase_next     = PH_TDIV;
                    end
                end
            end

            PH_TDIV:
            begin
                if (div_stat.done)
                begin
                    m_next     = div_quo[22:0];
                    cnt_next   = 3'd0;
                    phase_next = PH_CUBIC;
                end
            end

            // n^2, n^3, then the cubic summed in Q.20
            PH_CUBIC:
            begin
                cnt_next = cnt_reg + 3'd1;
                case (cnt_reg)
                    3'd1: m2_next  = p_reg[45:16];
                    3'd3: m3_next  = p_reg[52:16];
                    3'd5: acc_next = CUBIC_OFFSET + signed'(p_reg[63:0]);
                    3'd6: acc_next = sum_ap;
                    3'd7:
                    begin
                        if (sum_ap[63])
                        begin
                            bad_next  = 1'b1;
                            temp_next = 16'd0;
                        end
                        else if (sum_ap[63:36] != 28'd0)
                        begin
                            bad_next  = 1'b1;
                            temp_next = 16'hFFFF;
                        end
                        else
                            temp_next = sum_ap[35:20];
                        cnt_next   = 3'd0;
                        ch_next    = 2'd0;
                        phase_next = PH_GSET;
                    end
                    default: ;
                endcase
            end

            PH_GSET:
            begin
                cnt_next = 3'd0;
                if (gdiv_d == 25'sd0)
                begin
                    est_next   = (!mean_g_reg[23] && mean_g_reg != 24'sd0)
                                 ? signed'({10'b0, GAIN_MAX_Q16}) : 28'sd0;
                    phase_next = PH_FILT;
                end
                else
                begin
                    gneg_next      = mean_g_reg[23] ^ gdiv_d[24];
                    div_ctrl.start = 1'b1;
                    div_ctrl.steps = STEP_W'(40);
                    div_num        = DIV_W'({green_mag, 16'b0});
                    div_dsh        = DIV_W'({gdiv_d_mag, 40'b0});
                    phase_next     = PH_GDIV;
                end
            end

            PH_GDIV:
            begin
                if (div_stat.done)
                begin
                    est_next   = gneg_reg ? -signed'({1'b0, est_mag}) : signed'({1'b0, est_mag});
                    phase_next = PH_FILT;
                end
            end

            PH_FILT:
            begin
                cnt_next = cnt_reg + 3'd1;
                case (cnt_reg)
                    3'd1: acc_next = signed'(p_reg[63:0]);
                    3'd2:
                    begin
                        if (ch_reg == 2'd0)
                            ared_next = filt_clamped;
                        else
                            ablu_next = filt_clamped;
                        cnt_next = 3'd0;
                        if (ch_reg == 2'd0)
                        begin
                            ch_next    = 2'd1;
                            phase_next = PH_GSET;
                        end
                        else
                            phase_next = PH_DONE;
                    end
                    default: ;
                endcase
            end

            // wait for the output register to be free
            PH_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load                    = 1'b1;
                    out_next.next_red_gain      = auto_en_reg ? ared_reg[17:8] : man_red_reg;
                    out_next.next_green_gain    = 10'd256;
                    out_next.next_blue_gain     = auto_en_reg ? ablu_reg[17:8] : man_blue_reg;
                    out_next.colour_temp_kelvin = temp_reg;
                    out_next.temp_invalid       = bad_reg;
                    phase_next                  = PH_IDLE;
                end
            end

            default: phase_next = PH_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cnt_reg       <= 3'd0;
            ch_reg        <= 2'd0;
            ared_reg      <= 18'd65536;
            ablu_reg      <= 18'd65536;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            ch_reg    <= ch_next;
            ared_reg  <= ared_next;
            ablu_reg  <= ablu_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        in_reg     <= in_next;
        acc_reg    <= acc_next;
        p_reg      <= p_next;
        mean_r_reg <= mean_r_next;
        mean_g_reg <= mean_g_next;
        mean_b_reg <= mean_b_next;
        s_reg      <= s_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        neg_reg    <= neg_next;
        gneg_reg   <= gneg_next;
        bad_reg    <= bad_next;
        temp_reg   <= temp_next;
        m_reg      <= m_next;
        m2_reg     <= m2_next;
        m3_reg     <= m3_next;
        est_reg    <= est_next;
        out_reg    <= out_next;
    end

    gwawb_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .num   (div_num),
        .dsh   (div_dsh),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    assign in_stall  = (phase_reg != PH_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    // ---------------- assertions ----------------
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctrl.start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ared_reg <= GAIN_MAX_Q16) && (ablu_reg <= GAIN_MAX_Q16))
        else $error("stored gain above limit");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (phase_reg != PH_IDLE))
        else $error("sequencer did not start on an accepted word");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("output overwritten while stalled");

endmodule

[hdl/gwawb_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on gwawb_pkg for widths and the control/status structs.
module gwawb_div import gwawb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_ctrl_t        ctrl,
    input  logic [DIV_W-1:0] num,
    input  logic [DIV_W-1:0] dsh,
    output div_stat_t        stat,
    output logic [QUO_W-1:0] quo
);

    logic [DIV_W-1:0]  rem_reg,  rem_next;
    logic [DIV_W-1:0]  dsh_reg,  dsh_next;
    logic [QUO_W-1:0]  quo_reg,  quo_next;
    logic [STEP_W-1:0] left_reg, left_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_W:0]    rem_dbl;
    logic              take;

    // trial subtract of the shifted divisor
    assign rem_dbl = {rem_reg, 1'b0};
    assign take    = rem_dbl >= {1'b0, dsh_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        left_next = left_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            rem_next  = num;
            dsh_next  = dsh;
            quo_next  = '0;
            left_next = ctrl.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = take ? DIV_W'(rem_dbl - {1'b0, dsh_reg}) : rem_dbl[DIV_W-1:0];
            quo_next  = {quo_reg[QUO_W-2:0], take};
            left_next = left_reg - STEP_W'(1);
            if (left_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            left_reg <= left_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule

[tb/sv/tb.sv]
// Testbench for grey_world_awb_gain_update: directed table then random frames, checked
// against a built-in gain/temperature predictor or a typed-in expectation. Depends on gwawb_pkg.
`timescale 1ns / 1ps

module tb;
    import gwawb_pkg::*;

    localparam int LIMIT_CYCLES = 4000000;
    localparam int N_RANDOM     = 1500;
    localparam int DRAIN_CYCLES = 600;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    in_word_t    in_word;
    logic        out_valid;
    logic        out_stall;
    out_word_t   out_word;

    grey_world_awb_gain_update u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    // Predictor copy of registers and filter state
    logic        p_rgb_mode;
    logic        p_auto_en;
    logic [9:0]  p_man_red;
    logic [9:0]  p_man_blue;
    logic [8:0]  p_speed;
    longint      p_red_q16;
    longint      p_blue_q16;

    out_word_t   gains_due[$];
    int          errors;
    int          n_checked;
    int          n_invalid;
    longint      cycles;
    bit          drive_idle;
    bit          long_hold;

    // Directed rows: rgb-mode flag, word, typed-in expectation when known
    typedef struct {
        logic      rgb;
        in_word_t  w;
        bit        has_exp;
        out_word_t exp_w;
    } dir_row_t;

    dir_row_t    dir_rows[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t: timeout, %0d words outstanding", $time, gains_due.size());
            $display("FAIL grey_world_awb_gain_update");
            $finish;
        end
    end

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Divide an applied Q2.8 gain out of a Q12.12 mean
    function automatic longint remove_gain(longint mean, logic [9:0] gain);
        longint g;
        g = (gain == 10'd0) ? 1 : longint'(gain);
        return clampl((mean * 256) / g, -8388608, 8388607);
    endfunction

    // Correlated colour temperature; sets bad on saturation or zero divisor
    function automatic longint cct_kelvin(longint r, longint g, longint b, output bit bad);
        longint x, y, z, s, num, den, n, n2, n3, t;
        longint unsigned un, ud, q, rem, frac, m, m2, m3;
        bit neg;
        bad = 1'b0;
        x = -9360 * r + 101531 * g - 62679 * b;
        y = -21277 * r + 103440 * g - 47966 * b;
        z = -44697 * r + 50511 * g + 36918 * b;
        s = x + y + z;
        den = 12177 * s - y * 65536;
        if (s == 0 || den == 0)
        begin
            bad = 1'b1;
            return 0;
        end
        num = x * 65536 - 21758 * s;
        neg = (num < 0) != (den < 0);
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        q = un / ud;
        if (q >= 128)
        begin
            m = 8388607;
            bad = 1'b1;
        end
        else
        begin
            rem = un % ud;
            frac = 0;
            for (int i = 0; i < 16; i++)
            begin
                rem = rem << 1;
                frac = frac << 1;
                if (rem >= ud)
                begin
                    rem = rem - ud;
                    frac = frac | 1;
                end
            end
            m = (q << 16) | frac;
        end
        m2 = (m * m) >> 16;
        m3 = (m2 * m) >> 16;
        n = neg ? -longint'(m) : longint'(m);
        n2 = longint'(m2);
        n3 = neg ? -longint'(m3) : longint'(m3);
        t = 7184 * n3 + 56400 * n2 + 109173 * n + 64'sd5788481126;
        if (t < 0)
        begin
            bad = 1'b1;
            return 0;
        end
        t = t >>> 20;
        if (t > 65535)
        begin
            bad = 1'b1;
            return 65535;
        end
        return t;
    endfunction

    function automatic longint filter_gain(longint green, longint other, longint stored,
                                           longint spd);
        longint d, est;
        d = other + 4096;
        if (d == 0)
            est = green > 0 ? longint'(GAIN_MAX_Q16) : 0;
        else
            est = (green * 65536) / d;
        return clampl((spd * est + (256 - spd) * stored) / 256, 0, longint'(GAIN_MAX_Q16));
    endfunction

    // Advance the predictor by one frame and return its gains
    function automatic out_word_t next_frame_gains(in_word_t w);
        longint r, g, b, yv, cb, cr, spd, kel;
        bit bad;
        out_word_t o;
        if (p_rgb_mode)
        begin
            g = longint'(w.mean_y_or_green) * 4096;
            b = longint'(w.mean_cb_or_blue) * 4096;
            r = longint'(w.mean_cr_or_red) * 4096;
        end
        else
        begin
            yv = longint'(w.mean_y_or_green) - 16;
            cb = longint'(w.mean_cb_or_blue) - 128;
            cr = longint'(w.mean_cr_or_red) - 128;
            r = 4766 * yv - 255 * cb + 6557 * cr;
            g = 4766 * yv - 1657 * cb - 3256 * cr;
            b = 4766 * yv + 8156 * cb - 102 * cr;
        end
        r = remove_gain(r, w.applied_red_gain);
        g = remove_gain(g, w.applied_green_gain);
        b = remove_gain(b, w.applied_blue_gain);
        kel = cct_kelvin(r, g, b, bad);
        spd = p_speed > 9'd256 ? 256 : longint'(p_speed);
        p_red_q16 = filter_gain(g, r, p_red_q16, spd);
        p_blue_q16 = filter_gain(g, b, p_blue_q16, spd);
        if (p_auto_en)
        begin
            o.next_red_gain = p_red_q16[17:8];
            o.next_blue_gain = p_blue_q16[17:8];
        end
        else
        begin
            o.next_red_gain = p_man_red;
            o.next_blue_gain = p_man_blue;
        end
        o.next_green_gain = 10'd256;
        o.colour_temp_kelvin = kel[15:0];
        o.temp_invalid = bad;
        return o;
    endfunction

    // Register write: setup then access, driven on falling edges
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_RGB_MODE:    p_rgb_mode = val[0];
            REG_AUTO_ENABLE: p_auto_en = val[0];
            REG_MANUAL_RED:  p_man_red = val[9:0];
            REG_MANUAL_BLUE: p_man_blue = val[9:0];
            REG_SPEED:       p_speed = val[8:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic rgb, logic auto_on, logic [9:0] mr, logic [9:0] mb,
                            logic [8:0] spd);
        reg_write(REG_RGB_MODE, {31'd0, rgb});
        reg_write(REG_AUTO_ENABLE, {31'd0, auto_on});
        reg_write(REG_MANUAL_RED, {22'd0, mr});
        reg_write(REG_MANUAL_BLUE, {22'd0, mb});
        reg_write(REG_SPEED, {23'd0, spd});
    endtask

    task automatic wait_drained();
        while (gains_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Offer one word, hold it until accepted, queue its expectation
    task automatic send_frame(in_word_t w, bit use_exp, out_word_t exp_w);
        out_word_t predicted;
        // valid is low here; offer on a later falling edge
        if (drive_idle && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) @(negedge clk);
        else
            @(negedge clk);
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = next_frame_gains(w);
        gains_due.push_back(use_exp ? exp_w : predicted);
        if (use_exp && predicted != exp_w)
            $display("%0t: table row disagrees with predictor exp=%h pred=%h",
                     $time, exp_w, predicted);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    function automatic in_word_t rand_frame(bit typical);
        in_word_t w;
        w = in_word_t'({$urandom, $urandom});
        if (typical)
        begin
            w.mean_y_or_green = 8'($urandom_range(40, 220));
            w.mean_cb_or_blue = 8'($urandom_range(90, 170));
            w.mean_cr_or_red = 8'($urandom_range(90, 170));
            w.applied_red_gain = 10'($urandom_range(128, 700));
            w.applied_green_gain = 10'($urandom_range(200, 320));
            w.applied_blue_gain = 10'($urandom_range(128, 700));
        end
        return w;
    endfunction

    // Receiver: random stall bursts, one long hold, comparison on accept
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (long_hold)
            out_stall <= 1'b1;
        else if (drive_idle && $urandom_range(0, 4) == 0)
            out_stall <= 1'b1;
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (gains_due.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, out_word);
                errors++;
            end
            else
            begin
                e = gains_due.pop_front();
                n_checked++;
                if (e.temp_invalid)
                    n_invalid++;
                if (out_word.next_red_gain !== e.next_red_gain)
                begin
                    $display("%0t: red gain exp=%0d got=%0d", $time,
                             e.next_red_gain, out_word.next_red_gain);
                    errors++;
                end
                if (out_word.next_green_gain !== e.next_green_gain)
                begin
                    $display("%0t: green gain exp=%0d got=%0d", $time,
                             e.next_green_gain, out_word.next_green_gain);
                    errors++;
                end
                if (out_word.next_blue_gain !== e.next_blue_gain)
                begin
                    $display("%0t: blue gain exp=%0d got=%0d", $time,
                             e.next_blue_gain, out_word.next_blue_gain);
                    errors++;
                end
                if (out_word.colour_temp_kelvin !== e.colour_temp_kelvin)
                begin
                    $display("%0t: temperature exp=%0d got=%0d", $time,
                             e.colour_temp_kelvin, out_word.colour_temp_kelvin);
                    errors++;
                end
                if (out_word.temp_invalid !== e.temp_invalid)
                begin
                    $display("%0t: invalid flag exp=%0b got=%0b", $time,
                             e.temp_invalid, out_word.temp_invalid);
                    errors++;
                end
            end
        end
    end

    function automatic dir_row_t mk_row(logic rgb, logic [7:0] m0, logic [7:0] m1,
                                        logic [7:0] m2, logic [9:0] gr, logic [9:0] gg,
                                        logic [9:0] gb);
        dir_row_t d;
        d.rgb = rgb;
        d.w = '{m0, m1, m2, gr, gg, gb};
        d.has_exp = 1'b0;
        d.exp_w = '0;
        return d;
    endfunction

    initial
    begin
        in_word_t w;
        dir_row_t d;
        int unsigned phase_len;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        in_word = '0;
        errors = 0;
        n_checked = 0;
        n_invalid = 0;
        cycles = 0;
        drive_idle = 1'b0;
        long_hold = 1'b0;
        p_rgb_mode = 1'b0;
        p_auto_en = 1'b1;
        p_man_red = 10'd256;
        p_man_blue = 10'd256;
        p_speed = 9'd51;
        p_red_q16 = 65536;
        p_blue_q16 = 65536;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table: black and white frames, full-scale means, zero and
        // full gains, zero divisors (all-zero RGB gives a zero-sum frame)
        d = mk_row(1'b1, 8'd0, 8'd0, 8'd0, 10'd256, 10'd256, 10'd256);
        d.has_exp = 1'b1;
        d.exp_w = '{10'd205, 10'd256, 10'd205, 16'd0, 1'b1};
        dir_rows.push_back(d);
        dir_rows.push_back(mk_row(1'b1, 8'd255, 8'd255, 8'd255, 10'd256, 10'd256, 10'd256));
        dir_rows.push_back(mk_row(1'b1, 8'd255, 8'd0, 8'd0, 10'd1, 10'd1023, 10'd1));
        dir_rows.push_back(mk_row(1'b1, 8'd128, 8'd10, 8'd200, 10'd0, 10'd0, 10'd0));
        dir_rows.push_back(mk_row(1'b1, 8'd0, 8'd255, 8'd255, 10'd1023, 10'd1023, 10'd1023));
        dir_rows.push_back(mk_row(1'b1, 8'd100, 8'd100, 8'd100, 10'd1023, 10'd1, 10'd1023));
        dir_rows.push_back(mk_row(1'b0, 8'd16, 8'd128, 8'd128, 10'd256, 10'd256, 10'd256));
        dir_rows.push_back(mk_row(1'b0, 8'd235, 8'd128, 8'd128, 10'd256, 10'd256, 10'd256));
        dir_rows.push_back(mk_row(1'b0, 8'd0, 8'd0, 8'd0, 10'd1, 10'd1, 10'd1));
        dir_rows.push_back(mk_row(1'b0, 8'd255, 8'd255, 8'd255, 10'd1, 10'd1, 10'd1));
        dir_rows.push_back(mk_row(1'b0, 8'd255, 8'd0, 8'd255, 10'd1023, 10'd300, 10'd2));
        dir_rows.push_back(mk_row(1'b0, 8'd128, 8'd255, 8'd0, 10'd0, 10'd512, 10'd1023));
        dir_rows.push_back(mk_row(1'b0, 8'd60, 8'd140, 8'd110, 10'd300, 10'd256, 10'd420));
        dir_rows.push_back(mk_row(1'b0, 8'd180, 8'd100, 8'd160, 10'd200, 10'd256, 10'd500));
        dir_rows.push_back(mk_row(1'b0, 8'd16, 8'd0, 8'd128, 10'd256, 10'd256, 10'd256));
        dir_rows.push_back(mk_row(1'b0, 8'd16, 8'd128, 8'd0, 10'd256, 10'd256, 10'd256));
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].rgb != p_rgb_mode)
            begin
                wait_drained();
                reg_write(REG_RGB_MODE, {31'd0, dir_rows[i].rgb});
            end
            send_frame(dir_rows[i].w, dir_rows[i].has_exp, dir_rows[i].exp_w);
        end

        // Random phases across register settings, extremes included
        drive_idle = 1'b1;
        for (int ph = 0; ph < 10; ph++)
        begin
            wait_drained();
            case (ph)
                0: set_regs(1'b0, 1'b1, 10'd0, 10'd1023, 9'd0);
                1: set_regs(1'b1, 1'b1, 10'd1023, 10'd0, 9'd256);
                2: set_regs(1'b0, 1'b0, 10'd1023, 10'd0, 9'd511);
                3: set_regs(1'b1, 1'b0, 10'h155, 10'h2aa, 9'd1);
                default: set_regs(1'($urandom_range(0, 1)), ($urandom_range(0, 3) != 0),
                                  10'($urandom_range(0, 1023)),
                                  10'($urandom_range(0, 1023)),
                                  9'($urandom_range(0, 511)));
            endcase
            if (ph == 9)
                drive_idle = 1'b0;
            phase_len = N_RANDOM / 10;
            for (int k = 0; k < phase_len; k++)
            begin
                // Long receiver hold while the sender keeps offering
                if (ph == 4 && k == 10)
                    fork
                        begin
                            long_hold = 1'b1;
                            repeat (3000) @(negedge clk);
                            long_hold = 1'b0;
                        end
                    join_none
                // Sender pause until every result is back
                if (ph == 6 && k == 50)
                    while (gains_due.size() != 0)
                        @(negedge clk);
                w = rand_frame($urandom_range(0, 4) != 0);
                send_frame(w, 1'b0, '0);
            end
        end

        while (gains_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Checked %0d result words (%0d with the invalid flag) over ten", n_checked,
                 n_invalid);
        $display("register settings in YCbCr and RGB mode, %0d mismatches", errors);
        if (errors == 0)
            $display("PASS grey_world_awb_gain_update");
        else
            $display("FAIL grey_world_awb_gain_update");
        $finish;
    end

endmodule

[grey_world_awb_gain_update.f]
hdl/gwawb_pkg.sv
hdl/gwawb_div.sv
hdl/grey_world_awb_gain_update.sv
tb/sv/tb.sv
